// ===== hdl/spq_pkg.sv =====
// Shared types, widths and codes for the sorted priority queue.
package spq_pkg;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int ACT_W      = 2;
	localparam int ST_W       = 2;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_W-1:0] count_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic   ins;
		logic   rem;
		value_t value;
	} ctrl_t;

endpackage

// ===== hdl/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
	logic                        valid;
	logic                        ready;
	logic [spq_pkg::ACT_W-1:0]   action;
	spq_pkg::value_t             value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface spq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [spq_pkg::ST_W-1:0]   status;
	spq_pkg::value_t            removed_value;
	spq_pkg::value_t            head_value;
	logic                       head_valid;
	spq_pkg::count_t            entry_count;

	modport source (output valid, output status, output removed_value, output head_value,
		output head_valid, output entry_count, input ready);
	modport sink   (input valid, input status, input removed_value, input head_value,
		input head_valid, input entry_count, output ready);
endinterface

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue, min first, as a row of compare-and-shift cells.
// One request is taken per cycle: all cells compare against the request value
// at once, and insert or remove shifts the row by one slot in the same cycle.
// The response is registered and appears in the cycle after the request, and the next
// request is taken in that same cycle unless the response side stalls. No clearing
// pass after reset; the stored count alone marks which slots hold data.
module sorted_priority_queue (
	input  logic             clk,
	input  logic             arst_n,
	spq_req_if.sink          req,
	spq_rsp_if.source        rsp
);

	localparam int DEPTH = spq_pkg::DEPTH;

	logic                     acc;
	logic                     full;
	logic                     empty;
	spq_pkg::ctrl_t           ctrl;
	spq_pkg::count_t          cnt_q;
	spq_pkg::count_t          cnt_nxt;
	logic [spq_pkg::ST_W-1:0] status;
	logic [DEPTH-1:0]         occ;
	logic [DEPTH-1:0]         go;
	logic [DEPTH-1:0]         hit;
	spq_pkg::value_t          cell_val [DEPTH];
	spq_pkg::value_t          cell_nxt [DEPTH];

	logic                     rsp_valid_q;
	logic [spq_pkg::ST_W-1:0] rsp_status_q;
	spq_pkg::value_t          rsp_removed_q;
	spq_pkg::value_t          rsp_head_q;
	logic                     rsp_head_valid_q;
	spq_pkg::count_t          rsp_count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = cnt_q == spq_pkg::CNT_W'(DEPTH);
	assign empty     = cnt_q == '0;

	assign ctrl.ins   = acc && (req.action == spq_pkg::ACT_INSERT) && !full;
	assign ctrl.rem   = acc && (req.action == spq_pkg::ACT_REMOVE) && !empty;
	assign ctrl.value = req.value;

	always_comb begin
		cnt_nxt = cnt_q;
		if (ctrl.ins) begin
			cnt_nxt = cnt_q + spq_pkg::CNT_W'(1);
		end else if (ctrl.rem) begin
			cnt_nxt = cnt_q - spq_pkg::CNT_W'(1);
		end
	end

	always_comb begin
		case (req.action)
			spq_pkg::ACT_INSERT: begin
				status = full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
			end
			spq_pkg::ACT_REMOVE: begin
				status = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
			end
			spq_pkg::ACT_SEARCH: begin
				if (empty) begin
					status = spq_pkg::ST_EMPTY;
				end else begin
					status = (|hit) ? spq_pkg::ST_DONE : spq_pkg::ST_MISS;
				end
			end
			default: begin
				status = spq_pkg::ST_DONE;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = spq_pkg::CNT_W'(i) < cnt_q;

		if (i == 0) begin : g_first
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (occ[i]),
				.left_go     (1'b0),
				.left_value  (ctrl.value),
				.right_value (cell_val[(i + 1) % DEPTH]),
				.go          (go[i]),
				.hit         (hit[i]),
				.value       (cell_val[i]),
				.value_nxt   (cell_nxt[i])
			);
		end else if (i == DEPTH - 1) begin : g_last
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (occ[i]),
				.left_go     (go[i - 1]),
				.left_value  (cell_val[i - 1]),
				.right_value (cell_val[i]),
				.go          (go[i]),
				.hit         (hit[i]),
				.value       (cell_val[i]),
				.value_nxt   (cell_nxt[i])
			);
		end else begin : g_mid
			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (occ[i]),
				.left_go     (go[i - 1]),
				.left_value  (cell_val[i - 1]),
				.right_value (cell_val[i + 1]),
				.go          (go[i]),
				.hit         (hit[i]),
				.value       (cell_val[i]),
				.value_nxt   (cell_nxt[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_status_q     <= status;
			rsp_removed_q    <= ctrl.rem ? cell_val[0] : '0;
			rsp_head_q       <= (cnt_nxt != '0) ? cell_nxt[0] : '0;
			rsp_head_valid_q <= cnt_nxt != '0;
			rsp_count_q      <= cnt_nxt;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.head_value    = rsp_head_q;
	assign rsp.head_valid    = rsp_head_valid_q;
	assign rsp.entry_count   = rsp_count_q;

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted row: holds a value, shifts right on insert, left on remove.
module spq_cell (
	input  logic            clk,
	input  spq_pkg::ctrl_t  ctrl,
	input  logic            occ,
	input  logic            left_go,
	input  spq_pkg::value_t left_value,
	input  spq_pkg::value_t right_value,
	output logic            go,
	output logic            hit,
	output spq_pkg::value_t value,
	output spq_pkg::value_t value_nxt
);

	spq_pkg::value_t value_q;

	// at or past the insert point
	assign go  = !occ || (value_q >= ctrl.value);
	assign hit = occ && (value_q == ctrl.value);
	assign value = value_q;

	always_comb begin
		value_nxt = value_q;
		if (ctrl.ins && go) begin
			value_nxt = left_go ? left_value : ctrl.value;
		end else if (ctrl.rem) begin
			value_nxt = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_nxt;
	end

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [spq_pkg::ST_W-1:0] status,
	input spq_pkg::value_t          removed_value,
	input spq_pkg::value_t          head_value,
	input logic                     head_valid,
	input spq_pkg::count_t          entry_count
);

	// stalled response stays valid and holds its status, head value and count
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(head_value)
			&& $stable(entry_count))
		else $error("response changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
		else $error("entry count above capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (head_valid == (entry_count != '0))
			&& (head_valid || head_value == '0))
		else $error("head flag disagrees with count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == spq_pkg::ST_EMPTY |-> entry_count == '0 && removed_value == '0)
		else $error("empty status with stored entries");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == spq_pkg::ST_FULL
			|-> entry_count == spq_pkg::CNT_W'(spq_pkg::DEPTH))
		else $error("full status below capacity");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.removed_value (rsp.removed_value),
	.head_value    (rsp.head_value),
	.head_valid    (rsp.head_valid),
	.entry_count   (rsp.entry_count)
);
